[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ibmt_pkg.sv]
// ----------------------------------------------------------------------------
// Instrument bus master package
// Types, codes and the request frame builder shared by the master's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ibmt_pkg;

	localparam int REQ_BYTES = 8;
	localparam int REPLY_BYTES = 10;
	localparam int LEFT_W = $clog2(REQ_BYTES + 1);
	localparam int CNT_W = $clog2(REPLY_BYTES + 1);

	// Reply byte positions that carry meaning.
	localparam logic [CNT_W-1:0] RB_PV_HI = CNT_W'(1);
	localparam logic [CNT_W-1:0] RB_SV_HI = CNT_W'(3);
	localparam logic [CNT_W-1:0] RB_LEVEL = CNT_W'(4);
	localparam logic [CNT_W-1:0] RB_RUN = CNT_W'(5);
	localparam logic [CNT_W-1:0] RB_PVAL_HI = CNT_W'(7);
	localparam logic [CNT_W-1:0] RB_SUM_START = CNT_W'(8);
	localparam logic [CNT_W-1:0] RB_LAST = CNT_W'(REPLY_BYTES - 1);

	localparam logic [7:0] OP_WRITE = 8'h43;
	localparam logic [7:0] OP_READ = 8'h52;

	// Reciprocal of ten: (x * 52429) >> 19 equals x / 10 for any 16-bit x.
	localparam logic [15:0] DIV10_MUL = 16'd52429;
	localparam int DIV10_SHIFT = 19;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_BYTE  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		KIND_TX   = 2'd0,
		KIND_OK   = 2'd1,
		KIND_FAIL = 2'd2
	} kind_e;

	typedef enum logic [1:0] {
		CFG_DEV_ADDR = 2'd0,
		CFG_MAX_ATT  = 2'd1,
		CFG_TIMEOUT  = 2'd2
	} cfg_idx_e;

	typedef logic [REQ_BYTES-1:0][7:0] frame_t;

	typedef struct packed {
		logic [6:0]  dev_addr;
		logic [2:0]  max_att;
		logic [15:0] timeout;
	} ibmt_cfg_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        is_write;
		logic [7:0]  param_addr;
		logic [15:0] write_data;
		logic [7:0]  rx_byte;
	} ibmt_item_t;

	typedef struct packed {
		logic        valid;
		kind_e       kind;
		frame_t      frame;
		logic [12:0] pv;
		logic [12:0] sv;
		logic [7:0]  level;
		logic [7:0]  run;
		logic [15:0] pval;
	} ibmt_res_t;

	// Builds the request frame; element 0 is the first byte on the wire.
	function automatic frame_t build_frame(input logic wr, input logic [7:0] param,
			input logic [15:0] data, input logic [6:0] addr);
		logic [7:0]  op;
		logic [15:0] d;
		logic [15:0] sum;
		frame_t      f;
		op = wr ? OP_WRITE : OP_READ;
		d = wr ? data : 16'h0000;
		sum = {param, 8'h00} + {8'h00, op} + d + {9'd0, addr};
		f[0] = {1'b1, addr};
		f[1] = {1'b1, addr};
		f[2] = op;
		f[3] = param;
		f[4] = d[7:0];
		f[5] = d[15:8];
		f[6] = sum[7:0];
		f[7] = sum[15:8];
		return f;
	endfunction

endpackage

`default_nettype wire

[sv/ibmt_ctrl.sv]
// ----------------------------------------------------------------------------
// Instrument bus master transaction control
// Keeps the transaction state and turns one item into its burst of results.
// ----------------------------------------------------------------------------
`default_nettype none

module ibmt_ctrl import ibmt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire ibmt_item_t item,
	input  wire ibmt_cfg_t  cfg,
	output ibmt_res_t       res
);

	typedef enum logic {
		PH_IDLE,
		PH_WAIT
	} phase_e;

	phase_e            phase_q, phase_n;
	logic              req_write_q, req_write_n;
	logic [7:0]        req_param_q, req_param_n;
	logic [15:0]       req_data_q, req_data_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [15:0]       wait_q, wait_n;
	logic [2:0]        att_q, att_n;
	logic [7:0]        lo_q, lo_n;
	logic [15:0]       sum_q, sum_n;
	logic [12:0]       pv_q, pv_n;
	logic [12:0]       sv_q, sv_n;
	logic [7:0]        level_q, level_n;
	logic [7:0]        run_q, run_n;
	logic [15:0]       pval_q, pval_n;

	logic [15:0] rx_word;
	logic [31:0] div_prod;
	logic [12:0] div_q10;
	logic        send;
	logic        retry;

	// One shared multiplier divides the reply word just completed by ten.
	assign rx_word = {item.rx_byte, lo_q};
	assign div_prod = {16'h0000, rx_word} * {16'h0000, DIV10_MUL};
	assign div_q10 = div_prod[DIV10_SHIFT +: 13];

	always_comb begin
		phase_n = phase_q;
		req_write_n = req_write_q;
		req_param_n = req_param_q;
		req_data_n = req_data_q;
		count_n = count_q;
		wait_n = wait_q;
		att_n = att_q;
		lo_n = lo_q;
		sum_n = sum_q;
		pv_n = pv_q;
		sv_n = sv_q;
		level_n = level_q;
		run_n = run_q;
		pval_n = pval_q;
		send = 1'b0;
		retry = 1'b0;
		res = '0;
		res.kind = KIND_TX;

		if (fire) begin
			case (item.cmd)
				CMD_START: begin
					req_write_n = item.is_write;
					req_param_n = item.param_addr;
					req_data_n = item.write_data;
					att_n = (cfg.max_att == 3'd0) ? 3'd0 : cfg.max_att - 3'd1;
					send = 1'b1;
				end
				CMD_BYTE: begin
					if (phase_q == PH_WAIT) begin
						count_n = count_q + CNT_W'(1);
						if (!count_q[0]) begin
							lo_n = item.rx_byte;
						end
						if (count_q < RB_SUM_START) begin
							sum_n = count_q[0] ? sum_q + {item.rx_byte, 8'h00}
								: sum_q + {8'h00, item.rx_byte};
						end
						if (count_q == RB_PV_HI) begin
							pv_n = div_q10;
						end
						if (count_q == RB_SV_HI) begin
							sv_n = div_q10;
						end
						if (count_q == RB_LEVEL) begin
							level_n = item.rx_byte;
						end
						if (count_q == RB_RUN) begin
							run_n = item.rx_byte;
						end
						if (count_q == RB_PVAL_HI) begin
							pval_n = rx_word;
						end
						if (count_q == RB_LAST) begin
							if (rx_word == sum_q + {9'd0, cfg.dev_addr}) begin
								phase_n = PH_IDLE;
								count_n = '0;
								wait_n = '0;
								res.valid = 1'b1;
								res.kind = KIND_OK;
								res.pv = pv_q;
								res.sv = sv_q;
								res.level = level_q;
								res.run = run_q;
								res.pval = pval_q;
							end else begin
								retry = 1'b1;
							end
						end
					end
				end
				CMD_TICK: begin
					if (phase_q == PH_WAIT) begin
						if (wait_q > 16'd1) begin
							wait_n = wait_q - 16'd1;
						end else begin
							retry = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		if (retry) begin
			if (att_q != 3'd0) begin
				att_n = att_q - 3'd1;
				send = 1'b1;
			end else begin
				phase_n = PH_IDLE;
				count_n = '0;
				wait_n = '0;
				res.valid = 1'b1;
				res.kind = KIND_FAIL;
			end
		end

		if (send) begin
			phase_n = PH_WAIT;
			count_n = '0;
			sum_n = '0;
			wait_n = (cfg.timeout == 16'd0) ? 16'd1 : cfg.timeout;
			res.valid = 1'b1;
			res.kind = KIND_TX;
			res.frame = build_frame(req_write_n, req_param_n, req_data_n, cfg.dev_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			req_write_q <= 1'b0;
			req_param_q <= '0;
			req_data_q <= '0;
			count_q <= '0;
			wait_q <= '0;
			att_q <= '0;
			sum_q <= '0;
		end else begin
			phase_q <= phase_n;
			req_write_q <= req_write_n;
			req_param_q <= req_param_n;
			req_data_q <= req_data_n;
			count_q <= count_n;
			wait_q <= wait_n;
			att_q <= att_n;
			sum_q <= sum_n;
		end
	end

	// Reply payload bytes; only read after being written in the same reply.
	always_ff @(posedge clk) begin
		lo_q <= lo_n;
		pv_q <= pv_n;
		sv_q <= sv_n;
		level_q <= level_n;
		run_q <= run_n;
		pval_q <= pval_n;
	end

endmodule

`default_nettype wire

[sv/instrument_bus_master_transaction_top.sv]
// ----------------------------------------------------------------------------
// Instrument bus master transaction
// Master side of a serial instrument protocol with checksum and retries.
// ----------------------------------------------------------------------------
// A start item latches read or write, the parameter address and the write
// data, and produces eight transmit-byte results: the request frame, the last
// one marked by last_of_run. Received-byte items fill a ten-byte reply; the
// tenth byte closes it, and the block then reports success with the decoded
// fields or, on a checksum mismatch, resends the request. Tick items count
// down the reply timeout, and an expired timeout also resends. When all
// attempts are used the block reports failure. Items that cause no result can
// arrive in every cycle while the result register can load. A start item or
// a retry holds the output register while the frame bytes shift out one per
// cycle as out_ready allows, so the item after it is taken as soon as the
// last frame byte leaves. Configuration is written through its own port with
// ready always high, and must only change while no transaction is pending.
`default_nettype none

`include "assert_macros.svh"

module instrument_bus_master_transaction_top import ibmt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// Input item channel.
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic        is_write,
	input  wire logic [7:0]  param_addr,
	input  wire logic [15:0] write_data,
	input  wire logic [7:0]  rx_byte,
	// Result item channel.
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       tx_byte,
	output logic             last_of_run,
	output logic [12:0]      pv_degrees,
	output logic [12:0]      sv_degrees,
	output logic [7:0]       output_level,
	output logic [7:0]       run_state,
	output logic [15:0]      param_value
);

	ibmt_cfg_t  cfg_q;
	ibmt_item_t item_s1;
	logic       in_valid_s1;
	ibmt_res_t  res;
	logic       fire;
	logic       can_load;
	logic       out_take;

	logic              out_valid_q;
	logic [LEFT_W-1:0] out_left_q;
	kind_e             kind_q;
	frame_t            frame_q;
	logic [12:0]       pv_q;
	logic [12:0]       sv_q;
	logic [7:0]        level_q;
	logic [7:0]        run_q;
	logic [15:0]       pval_q;

	// Configuration registers; writes outside the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr <= 7'd1;
			cfg_q.max_att <= 3'd5;
			cfg_q.timeout <= 16'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEV_ADDR: cfg_q.dev_addr <= cfg_data[6:0];
				CFG_MAX_ATT:  cfg_q.max_att <= cfg_data[2:0];
				CFG_TIMEOUT:  cfg_q.timeout <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The result register can take a new burst when it is empty or when its
	// final result is being taken in this cycle.
	assign out_take = out_valid_q && out_ready;
	assign can_load = !out_valid_q || (out_ready && out_left_q == LEFT_W'(1));
	assign fire = in_valid_s1 && can_load;
	assign in_ready = !in_valid_s1 || can_load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			in_valid_s1 <= 1'b1;
		end else if (fire) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd <= cmd;
			item_s1.is_write <= is_write;
			item_s1.param_addr <= param_addr;
			item_s1.write_data <= write_data;
			item_s1.rx_byte <= rx_byte;
		end
	end

	ibmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Result register: holds a burst and shifts the frame one byte per result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_left_q <= '0;
			kind_q <= KIND_TX;
		end else if (fire && res.valid) begin
			out_valid_q <= 1'b1;
			out_left_q <= (res.kind == KIND_TX) ? LEFT_W'(REQ_BYTES) : LEFT_W'(1);
			kind_q <= res.kind;
		end else if (out_take) begin
			out_left_q <= out_left_q - LEFT_W'(1);
			out_valid_q <= (out_left_q != LEFT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			frame_q <= res.frame;
			pv_q <= res.pv;
			sv_q <= res.sv;
			level_q <= res.level;
			run_q <= res.run;
			pval_q <= res.pval;
		end else if (out_take) begin
			frame_q <= {8'h00, frame_q[REQ_BYTES-1:1]};
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign tx_byte = frame_q[0];
	assign last_of_run = (out_left_q == LEFT_W'(1));
	assign pv_degrees = pv_q;
	assign sv_degrees = sv_q;
	assign output_level = level_q;
	assign run_state = run_q;
	assign param_value = pval_q;

	// The burst counter is nonzero exactly while a result is held.
	`ASSERT_ALWAYS(a_left_tracks_valid, out_valid_q == (out_left_q != '0), "burst count mismatch")
	// A status result never forms a multi-item burst.
	`ASSERT_ALWAYS(a_status_single, !out_valid_q || kind_q == KIND_TX || out_left_q == LEFT_W'(1), "status burst too long")
	// Taking a frame byte that is not the last one leaves the rest of the burst.
	`ASSERT_NEXT(a_burst_advance, out_take && out_left_q > LEFT_W'(1), out_valid_q && out_left_q == $past(out_left_q) - LEFT_W'(1), "frame burst did not advance")
	// An item held in the input register waits until the result register frees.
	`ASSERT_NEXT(a_input_held, in_valid_s1 && !can_load, in_valid_s1 && $stable(item_s1), "stalled item lost")

endmodule

`default_nettype wire

[dv/tb_instrument_bus_master_transaction_top.sv]
// ----------------------------------------------------------------------------
// Instrument bus master transaction testbench
// Drives start, received-byte and tick items with random handshake gaps,
// predicts every request byte and status report, and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_instrument_bus_master_transaction_top;
	import ibmt_pkg::*;

	// The only command code that the package leaves without a name.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Cycles allowed after the last result for the frame shifter to settle.
	localparam int DRAIN_CYCLES = 24;
	// Long stall of the result side, so that the block backs up into its input.
	localparam int LONG_HOLD = 400;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int N_PHASES = 5;

	// Reply with every field at an extreme; byte 0 in the low bits. With
	// device address 1 its checksum word is 0x02FE, held in bytes 8 and 9.
	localparam logic [REPLY_BYTES*8-1:0] EXTREME_REPLY = 80'h02FE_FFFF_02FF_0000_FFFF;

	typedef enum logic {
		LINK_IDLE,
		LINK_WAIT
	} link_phase_e;

	typedef struct packed {
		kind_e       kind;
		logic [7:0]  tx;
		logic        last;
		logic [12:0] pv;
		logic [12:0] sv;
		logic [7:0]  level;
		logic [7:0]  run;
		logic [15:0] pval;
	} bus_result_t;

	// One row of the directed table: either a register write or an item,
	// optionally with the final result of that item typed in by hand.
	typedef struct {
		bit          is_cfg;
		cfg_idx_e    reg_idx;
		logic [15:0] reg_val;
		ibmt_item_t  item;
		bit          typed;
		bus_result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic        is_write;
	logic [7:0]  param_addr;
	logic [15:0] write_data;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        last_of_run;
	logic [12:0] pv_degrees;
	logic [12:0] sv_degrees;
	logic [7:0]  output_level;
	logic [7:0]  run_state;
	logic [15:0] param_value;

	instrument_bus_master_transaction_top dut (.*);

	// Results still owed by the block, oldest first.
	bus_result_t expected_q [$];
	stim_row_t   stim_table [$];

	// Predictor copy of the configuration registers.
	logic [6:0]  cfg_dev;
	logic [2:0]  cfg_tries;
	logic [15:0] cfg_ticks;

	// Predictor copy of the transaction state.
	link_phase_e link_phase;
	logic        held_write;
	logic [7:0]  held_param;
	logic [15:0] held_data;
	logic [7:0]  reply_buf [REPLY_BYTES];
	logic [3:0]  reply_cnt;
	logic [15:0] ticks_left;
	logic [2:0]  tries_left;

	int fail_count;
	int item_count;
	int predicted_count;
	bit tx_idle;
	bit rx_idle;
	bit hold_request;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// The run ends here if the block stops answering.
	initial begin : watchdog
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic bus_result_t mk_result(input kind_e k, input logic [7:0] tx,
			input logic last, input logic [12:0] pv, input logic [12:0] sv,
			input logic [7:0] lvl, input logic [7:0] run, input logic [15:0] pval);
		bus_result_t r;
		r.kind = k;
		r.tx = tx;
		r.last = last;
		r.pv = pv;
		r.sv = sv;
		r.level = lvl;
		r.run = run;
		r.pval = pval;
		return r;
	endfunction

	function automatic ibmt_item_t mk_item(input logic [1:0] c, input logic wr,
			input logic [7:0] param, input logic [15:0] data, input logic [7:0] rx);
		ibmt_item_t it;
		it.cmd = c;
		it.is_write = wr;
		it.param_addr = param;
		it.write_data = data;
		it.rx_byte = rx;
		return it;
	endfunction

	function automatic string show(input bus_result_t r);
		return $sformatf("kind %0d tx %02h last %0d pv %0d sv %0d level %02h run %02h value %04h",
			r.kind, r.tx, r.last, r.pv, r.sv, r.level, r.run, r.pval);
	endfunction

	// Only the first ten failures are printed; the rest are just counted.
	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// Biased toward the all-zero and all-one bytes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	function automatic logic [15:0] reply_word(input int at);
		return {reply_buf[at + 1], reply_buf[at]};
	endfunction

	function automatic void push_tx(input logic [7:0] b, input logic last);
		expected_q.push_back(mk_result(KIND_TX, b, last, '0, '0, '0, '0, '0));
	endfunction

	// Queues the eight request bytes and rearms reply collection and timer.
	function automatic void queue_request();
		logic [7:0]  op;
		logic [7:0]  hdr;
		logic [15:0] d;
		logic [15:0] sum;
		op = held_write ? OP_WRITE : OP_READ;
		d = held_write ? held_data : 16'h0000;
		sum = 16'(held_param * 256 + op + d + cfg_dev);
		hdr = 8'h80 + cfg_dev;
		push_tx(hdr, 1'b0);
		push_tx(hdr, 1'b0);
		push_tx(op, 1'b0);
		push_tx(held_param, 1'b0);
		push_tx(d[7:0], 1'b0);
		push_tx(d[15:8], 1'b0);
		push_tx(sum[7:0], 1'b0);
		push_tx(sum[15:8], 1'b1);
		reply_cnt = '0;
		ticks_left = (cfg_ticks == 16'd0) ? 16'd1 : cfg_ticks;
		link_phase = LINK_WAIT;
	endfunction

	function automatic void resend_or_fail();
		if (tries_left > 3'd0) begin
			tries_left = tries_left - 3'd1;
			queue_request();
		end else begin
			link_phase = LINK_IDLE;
			reply_cnt = '0;
			ticks_left = '0;
			expected_q.push_back(mk_result(KIND_FAIL, 8'h00, 1'b1, '0, '0, '0, '0, '0));
		end
	endfunction

	// Advances the predictor by one accepted item. Returns 0 for an item that
	// the block ignores; predicted_count tells how many results it caused.
	function automatic bit predict_item(input ibmt_item_t it);
		int          depth_at_entry;
		bit          taken;
		logic [15:0] total;
		depth_at_entry = expected_q.size();
		taken = 1'b1;
		case (it.cmd)
			CMD_START: begin
				held_write = it.is_write;
				held_param = it.param_addr;
				held_data = it.write_data;
				tries_left = (cfg_tries == 3'd0) ? 3'd0 : cfg_tries - 3'd1;
				queue_request();
			end
			CMD_BYTE: begin
				if (link_phase != LINK_WAIT) begin
					taken = 1'b0;
				end else begin
					if (reply_cnt < REPLY_BYTES) begin
						reply_buf[reply_cnt] = it.rx_byte;
						reply_cnt = reply_cnt + 4'd1;
					end
					if (reply_cnt == REPLY_BYTES) begin
						total = 16'(reply_word(0) + reply_word(2) + reply_word(4) +
							reply_word(6) + cfg_dev);
						if (total != reply_word(8)) begin
							resend_or_fail();
						end else begin
							link_phase = LINK_IDLE;
							reply_cnt = '0;
							ticks_left = '0;
							expected_q.push_back(mk_result(KIND_OK, 8'h00, 1'b1,
								13'(reply_word(0) / 10), 13'(reply_word(2) / 10),
								reply_buf[4], reply_buf[5], reply_word(6)));
						end
					end
				end
			end
			CMD_TICK: begin
				if (link_phase != LINK_WAIT) begin
					taken = 1'b0;
				end else if (ticks_left > 16'd1) begin
					ticks_left = ticks_left - 16'd1;
				end else begin
					resend_or_fail();
				end
			end
			default: begin
				taken = 1'b0;
			end
		endcase
		predicted_count = expected_q.size() - depth_at_entry;
		return taken;
	endfunction

	// Offers one item after a random gap and predicts it once it is taken.
	// Valid stays high after acceptance; the next call or a drain replaces it
	// before the following rising edge.
	task automatic drive_item(input ibmt_item_t it);
		int gap;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		is_write <= it.is_write;
		param_addr <= it.param_addr;
		write_data <= it.write_data;
		rx_byte <= it.rx_byte;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (predict_item(it)) begin
			item_count++;
		end
	endtask

	// Stops offering items and waits until every owed result has come.
	task automatic drain(input int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_DEV_ADDR: begin
				cfg_dev = val[6:0];
			end
			CFG_MAX_ATT: begin
				cfg_tries = val[2:0];
			end
			CFG_TIMEOUT: begin
				cfg_ticks = val;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Finishes the reply under way with random content. A good reply carries
	// the right checksum over whatever bytes are already collected, unless the
	// checksum low byte has already arrived. Ticks are mixed in while they
	// cannot expire the timer.
	task automatic send_reply(input bit good);
		logic [7:0]  b [REPLY_BYTES];
		logic [15:0] total;
		int          first;
		int          k;
		first = reply_cnt;
		for (k = 0; k < REPLY_BYTES; k++) begin
			b[k] = (k < first) ? reply_buf[k] : pick_byte();
		end
		total = 16'(cfg_dev);
		for (k = 0; k < 8; k += 2) begin
			total = total + {b[k + 1], b[k]};
		end
		if (!good) begin
			total = total + 16'($urandom_range(1, 65535));
		end
		if (first <= 8) begin
			b[8] = total[7:0];
		end
		b[9] = total[15:8];
		for (k = first; k < REPLY_BYTES; k++) begin
			if (ticks_left > 16'd2 && $urandom_range(0, 7) == 0) begin
				drive_item(mk_item(CMD_TICK, 1'($urandom), 8'($urandom), 16'($urandom),
					8'($urandom)));
			end
			drive_item(mk_item(CMD_BYTE, 1'($urandom), 8'($urandom), 16'($urandom), b[k]));
		end
	endtask

	// One transaction: a start, then a mix of good and corrupt replies,
	// timeouts, partial replies and stray items until it ends or is dropped.
	task automatic run_transaction();
		int rounds;
		int style;
		int n;
		drive_item(mk_item(CMD_START, 1'($urandom), pick_byte(), {pick_byte(), pick_byte()},
			8'($urandom)));
		rounds = 0;
		while (link_phase == LINK_WAIT && rounds < 12) begin
			rounds++;
			style = $urandom_range(0, 15);
			if (style < 7) begin
				send_reply(1'b1);
			end else if (style < 10) begin
				send_reply(1'b0);
			end else if (style < 12 && ticks_left <= 16'd40) begin
				n = ticks_left;
				repeat (n) begin
					drive_item(mk_item(CMD_TICK, 1'($urandom), 8'($urandom), 16'($urandom),
						8'($urandom)));
				end
			end else if (style < 14) begin
				// A partial reply; half the time a new start then drops it.
				n = $urandom_range(1, 9);
				repeat (n) begin
					drive_item(mk_item(CMD_BYTE, 1'($urandom), 8'($urandom), 16'($urandom),
						pick_byte()));
				end
				if ($urandom_range(0, 1) == 1) begin
					return;
				end
			end else begin
				drive_item(mk_item(2'($urandom_range(0, 3)), 1'($urandom), 8'($urandom),
					16'($urandom), 8'($urandom)));
			end
		end
	endtask

	task automatic add_item(input ibmt_item_t it);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = CFG_DEV_ADDR;
		row.reg_val = '0;
		row.item = it;
		row.typed = 1'b0;
		row.want = '0;
		stim_table.push_back(row);
	endtask

	task automatic add_checked(input ibmt_item_t it, input bus_result_t want);
		stim_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = CFG_DEV_ADDR;
		row.reg_val = '0;
		row.item = it;
		row.typed = 1'b1;
		row.want = want;
		stim_table.push_back(row);
	endtask

	task automatic add_cfg(input cfg_idx_e idx, input logic [15:0] val);
		stim_row_t row;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		row.item = '0;
		row.typed = 1'b0;
		row.want = '0;
		stim_table.push_back(row);
	endtask

	// Result side: a random stall before each result, and once a long hold
	// that lets the block fill up and stop taking items.
	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 12) : 0;
			if (hold_request) begin
				stall = LONG_HOLD;
				hold_request = 1'b0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// Every accepted result is checked against the oldest expectation.
	always @(posedge clk) begin : result_check
		bus_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got = mk_result(kind_e'(kind), tx_byte, last_of_run, pv_degrees, sv_degrees,
				output_level, run_state, param_value);
			if (expected_q.size() == 0) begin
				note_failure({"Unexpected result: ", show(got)});
			end else begin
				if (got !== expected_q[0]) begin
					note_failure($sformatf("Mismatch: expected %s, got %s",
						show(expected_q[0]), show(got)));
				end
				void'(expected_q.pop_front());
			end
		end
	end

	initial begin : stimulus
		int          p;
		int          k;
		int          phase_start;
		bit          paused;
		logic [6:0]  dev;
		logic [2:0]  tries;
		logic [15:0] ticks;

		// Every input is known from time zero, and the predictor starts from
		// the reset values of the block.
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DEV_ADDR;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_START;
		is_write = 1'b0;
		param_addr = '0;
		write_data = '0;
		rx_byte = '0;
		cfg_dev = 7'd1;
		cfg_tries = 3'd5;
		cfg_ticks = 16'd200;
		link_phase = LINK_IDLE;
		held_write = 1'b0;
		held_param = '0;
		held_data = '0;
		reply_cnt = '0;
		ticks_left = '0;
		tries_left = '0;
		fail_count = 0;
		item_count = 0;
		predicted_count = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_request = 1'b0;
		paused = 1'b0;

		// Directed table. Bytes and ticks while idle and the unused command
		// must be ignored. The first start uses the reset configuration, the
		// second one replaces a pending request with the largest write. A
		// partial reply is then thrown away by a third start, which is
		// answered with the extreme reply.
		add_item(mk_item(CMD_TICK, 1'b0, 8'h00, 16'h0000, 8'h00));
		add_item(mk_item(CMD_BYTE, 1'b1, 8'hFF, 16'hFFFF, 8'hFF));
		add_item(mk_item(CMD_UNUSED, 1'b1, 8'hA5, 16'h5A5A, 8'hC3));
		add_checked(mk_item(CMD_START, 1'b0, 8'h00, 16'hFFFF, 8'h00),
			mk_result(KIND_TX, 8'h00, 1'b1, '0, '0, '0, '0, '0));
		add_checked(mk_item(CMD_START, 1'b1, 8'hFF, 16'hFFFF, 8'h00),
			mk_result(KIND_TX, 8'hFF, 1'b1, '0, '0, '0, '0, '0));
		add_item(mk_item(CMD_BYTE, 1'b0, 8'h00, 16'h0000, 8'h11));
		add_item(mk_item(CMD_BYTE, 1'b0, 8'h00, 16'h0000, 8'h22));
		add_item(mk_item(CMD_START, 1'b0, 8'h80, 16'h1234, 8'h00));
		for (k = 0; k < REPLY_BYTES - 1; k++) begin
			add_item(mk_item(CMD_BYTE, 1'b0, 8'h00, 16'h0000, EXTREME_REPLY[8*k +: 8]));
		end
		add_checked(mk_item(CMD_BYTE, 1'b0, 8'h00, 16'h0000, EXTREME_REPLY[8*9 +: 8]),
			mk_result(KIND_OK, 8'h00, 1'b1, 13'd6553, 13'd0, 8'hFF, 8'h02, 16'hFFFF));
		// Zero attempts mean one transmission and a zero timeout means one
		// tick, so the first tick after the request reports failure.
		add_cfg(CFG_MAX_ATT, 16'd0);
		add_cfg(CFG_TIMEOUT, 16'd0);
		add_checked(mk_item(CMD_START, 1'b1, 8'h01, 16'h8000, 8'h00),
			mk_result(KIND_TX, 8'h81, 1'b1, '0, '0, '0, '0, '0));
		add_checked(mk_item(CMD_TICK, 1'b0, 8'h00, 16'h0000, 8'h00),
			mk_result(KIND_FAIL, 8'h00, 1'b1, '0, '0, '0, '0, '0));
		add_item(mk_item(CMD_TICK, 1'b1, 8'hFF, 16'hFFFF, 8'hFF));

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// A typed-in result overrides the prediction, so the block is held to
		// the hand-written value; a predictor that disagrees is a failure too.
		foreach (stim_table[r]) begin
			if (stim_table[r].is_cfg) begin
				drain(DRAIN_CYCLES);
				write_reg(stim_table[r].reg_idx, stim_table[r].reg_val);
			end else begin
				drive_item(stim_table[r].item);
				if (stim_table[r].typed) begin
					if (predicted_count == 0) begin
						note_failure({"Table row predicts no result, typed ",
							show(stim_table[r].want)});
					end else begin
						if (expected_q[expected_q.size() - 1] != stim_table[r].want) begin
							note_failure($sformatf("Table row typed %s, predictor %s",
								show(stim_table[r].want),
								show(expected_q[expected_q.size() - 1])));
						end
						expected_q[expected_q.size() - 1] = stim_table[r].want;
					end
				end
			end
		end

		// Random phases, each under its own configuration. The block is idle
		// and drained before every register write.
		for (p = 0; p < N_PHASES; p++) begin
			drain(DRAIN_CYCLES);
			case (p)
				0: begin
					dev = 7'd127;
					tries = 3'd7;
					ticks = 16'hFFFF;
				end
				1: begin
					dev = 7'd0;
					tries = 3'd1;
					ticks = 16'd1;
				end
				2: begin
					dev = 7'd42;
					tries = 3'd3;
					ticks = 16'd6;
				end
				3: begin
					dev = 7'($urandom_range(0, 127));
					tries = 3'd2;
					ticks = 16'($urandom_range(2, 12));
				end
				default: begin
					dev = 7'd85;
					tries = 3'd0;
					ticks = 16'd0;
				end
			endcase
			write_reg(CFG_DEV_ADDR, {9'd0, dev});
			write_reg(CFG_MAX_ATT, {13'd0, tries});
			write_reg(CFG_TIMEOUT, ticks);
			// The third phase runs both sides without gaps.
			tx_idle = (p != 2);
			rx_idle = (p != 2);
			if (p == 0) begin
				hold_request = 1'b1;
			end
			phase_start = item_count;
			while (item_count - phase_start < ITEMS_PER_PHASE) begin
				run_transaction();
				// Once, the sender stops until every result has come back.
				if (p == 1 && !paused && item_count - phase_start > ITEMS_PER_PHASE / 2) begin
					drain(0);
					paused = 1'b1;
				end
			end
			// Close any open transaction before the configuration changes.
			while (link_phase == LINK_WAIT) begin
				send_reply(1'b1);
			end
		end

		drain(DRAIN_CYCLES);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/ibmt_pkg.sv
sv/ibmt_ctrl.sv
sv/instrument_bus_master_transaction_top.sv
dv/tb_instrument_bus_master_transaction_top.sv
